FILE: rtl/core/one_pole_lowpass_highpass_cascade_defines.svh
// ---------------------------------------------------------------------------
// one_pole_lowpass_highpass_cascade_defines
// assertion macros shared by the filter cascade rtl
// ---------------------------------------------------------------------------
`ifndef ONE_POLE_LOWPASS_HIGHPASS_CASCADE_DEFINES_SVH
`define ONE_POLE_LOWPASS_HIGHPASS_CASCADE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define OPHC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OPHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ophc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ophc_pkg
// shared widths, types and saturation helper for the filter cascade
// ---------------------------------------------------------------------------
package ophc_pkg;

	localparam int SAMPLE_W        = 32;
	localparam int COEFF_W         = 16;
	localparam int COEFF_FRAC_BITS = 16;
	localparam int STATE_W         = 48;
	localparam int STATE_FRAC_BITS = 16;
	// signed product of a state word and a zero-extended coefficient
	localparam int PROD_W          = STATE_W + COEFF_W + 1;
	// one guard bit for the three-term sums
	localparam int ACC_W           = PROD_W + 1;
	localparam int CFG_IDX_W       = 2;

	localparam logic [COEFF_W-1:0] LP_COEFF_RESET = '0;
	localparam logic [COEFF_W-1:0] HP_COEFF_RESET = '1;

	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic [COEFF_W-1:0]        coeff_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LP_ENABLE = 2'd0,
		CFG_HP_ENABLE = 2'd1,
		CFG_LP_COEFF  = 2'd2,
		CFG_HP_COEFF  = 2'd3
	} cfg_idx_t;

	// per-stage control
	typedef struct packed {
		logic update;  // take the new state value
		logic clear;   // zero the state
	} stage_ctrl_t;

	localparam state_t STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam state_t STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	// clamp a wide sum to the signed state range
	function automatic state_t sat_state(input acc_t v);
		state_t r;
		if (v > acc_t'(STATE_MAX)) begin
			r = STATE_MAX;
		end else if (v < acc_t'(STATE_MIN)) begin
			r = STATE_MIN;
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/ophc_lowpass.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ophc_lowpass
// one-pole low-pass, lp += a * sat(x - lp), with its state register
// ---------------------------------------------------------------------------
module ophc_lowpass (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ophc_pkg::stage_ctrl_t ctrl,
	input  ophc_pkg::coeff_t     coeff,
	input  ophc_pkg::state_t     v_in,
	output ophc_pkg::state_t     v_out
);

	ophc_pkg::state_t                       state_q;
	ophc_pkg::state_t                       diff;
	logic signed [ophc_pkg::PROD_W-1:0]     prod;
	logic signed [ophc_pkg::PROD_W-1:0]     prod_sh;
	ophc_pkg::acc_t                         sum;

	always_comb begin
		diff    = ophc_pkg::sat_state(ophc_pkg::ACC_W'(v_in) - ophc_pkg::ACC_W'(state_q));
		prod    = ophc_pkg::PROD_W'(diff) * $signed({1'b0, coeff});
		prod_sh = prod >>> ophc_pkg::COEFF_FRAC_BITS;
		sum     = ophc_pkg::ACC_W'(state_q) + ophc_pkg::ACC_W'(prod_sh);
		v_out   = ophc_pkg::sat_state(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctrl.clear) begin
			state_q <= '0;
		end else if (ctrl.update) begin
			state_q <= v_out;
		end
	end

endmodule

FILE: rtl/core/ophc_highpass.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ophc_highpass
// one-pole dc blocker, hp = (u - prev) + r * hp, with its state registers
// ---------------------------------------------------------------------------
module ophc_highpass (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ophc_pkg::stage_ctrl_t ctrl,
	input  ophc_pkg::coeff_t     coeff,
	input  ophc_pkg::state_t     v_in,
	output ophc_pkg::state_t     v_out
);

	ophc_pkg::state_t                       state_q;
	ophc_pkg::state_t                       prev_q;
	logic signed [ophc_pkg::PROD_W-1:0]     prod;
	logic signed [ophc_pkg::PROD_W-1:0]     prod_sh;
	ophc_pkg::acc_t                         acc;

	// product uses only the stored output, so it runs alongside the low-pass
	always_comb begin
		prod    = ophc_pkg::PROD_W'(state_q) * $signed({1'b0, coeff});
		prod_sh = prod >>> ophc_pkg::COEFF_FRAC_BITS;
		acc     = ophc_pkg::ACC_W'(v_in) - ophc_pkg::ACC_W'(prev_q)
		        + ophc_pkg::ACC_W'(prod_sh);
		v_out   = ophc_pkg::sat_state(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			prev_q  <= '0;
		end else if (ctrl.clear) begin
			state_q <= '0;
			prev_q  <= '0;
		end else if (ctrl.update) begin
			state_q <= v_out;
			prev_q  <= v_in;
		end
	end

endmodule

FILE: rtl/core/one_pole_lowpass_highpass_cascade.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// one_pole_lowpass_highpass_cascade
// fixed-point one-pole low-pass followed by a one-pole dc blocker
// ---------------------------------------------------------------------------
// Takes one signed 32-bit audio sample per word and returns one filtered
// sample per word, in order, with tlast copied through. The block sustains one
// word per clock while the output is not stalled. Each word passes three
// register stages: the input register, loaded at the accepting edge, the
// filter update (both recursive multiply-adds close combinationally against
// their own state registers) and the output conversion register. Each stage
// (low-pass, high-pass) has its own enable; with both off the sample passes
// unchanged. Coefficients are unsigned Q0.16, state is signed 48-bit with 16
// fraction bits, and the output is the state divided by 2^16 truncated toward
// zero. Any write on the configuration port clears all filter state; writes
// are to be made only while no word is in flight, which the block itself
// does not enforce. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "one_pole_lowpass_highpass_cascade_defines.svh"

module one_pole_lowpass_highpass_cascade (
	input  logic                            clk,
	input  logic                            arst_n,

	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ophc_pkg::SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample_in
	input  logic                            s_axis_tlast,   // block_end

	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [ophc_pkg::SAMPLE_W-1:0]   m_axis_tdata,   // [31:0] sample_out
	output logic                            m_axis_tlast,   // block_end_out

	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ophc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ophc_pkg::COEFF_W-1:0]    cfg_data
);

	// configuration registers
	logic                  lp_en_q;
	logic                  hp_en_q;
	ophc_pkg::coeff_t      lp_coeff_q;
	ophc_pkg::coeff_t      hp_coeff_q;
	logic                  cfg_fire;

	// pipeline registers
	logic                                valid_s1;
	logic signed [ophc_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                last_s1;
	logic                                valid_s2;
	ophc_pkg::state_t                    v_s2;
	logic                                last_s2;
	logic                                valid_s3;
	logic [ophc_pkg::SAMPLE_W-1:0]       data_s3;
	logic                                last_s3;

	// handshake
	logic                  load_s2;
	logic                  load_s3;

	// datapath
	ophc_pkg::state_t      v_in;
	ophc_pkg::state_t      lp_out;
	ophc_pkg::state_t      v_lp;
	ophc_pkg::state_t      hp_out;
	ophc_pkg::state_t      v_hp;
	ophc_pkg::stage_ctrl_t lp_ctrl;
	ophc_pkg::stage_ctrl_t hp_ctrl;
	logic [ophc_pkg::SAMPLE_W-1:0] q_floor;
	logic                  round_up;
	logic [ophc_pkg::SAMPLE_W-1:0] q_out;

	// ---------------------------------------------------------------
	// configuration port: always ready, a write also clears the state
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_en_q    <= 1'b0;
			hp_en_q    <= 1'b0;
			lp_coeff_q <= ophc_pkg::LP_COEFF_RESET;
			hp_coeff_q <= ophc_pkg::HP_COEFF_RESET;
		end else if (cfg_fire) begin
			unique case (ophc_pkg::cfg_idx_t'(cfg_index))
				ophc_pkg::CFG_LP_ENABLE: lp_en_q    <= cfg_data[0];
				ophc_pkg::CFG_HP_ENABLE: hp_en_q    <= cfg_data[0];
				ophc_pkg::CFG_LP_COEFF:  lp_coeff_q <= cfg_data;
				ophc_pkg::CFG_HP_COEFF:  hp_coeff_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pipeline flow: each stage loads when it holds nothing or drains
	// ---------------------------------------------------------------
	assign load_s3       = valid_s2 && (!valid_s3 || m_axis_tready);
	assign load_s2       = valid_s1 && (!valid_s2 || load_s3);
	assign s_axis_tready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (!valid_s2 || load_s3) begin
				valid_s2 <= valid_s1;
			end
			if (!valid_s3 || m_axis_tready) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= $signed(s_axis_tdata);
			last_s1   <= s_axis_tlast;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: filter update; state moves only when the word moves on
	// ---------------------------------------------------------------
	// sample scaled into the state format, x * 2^16
	assign v_in = {sample_s1, {ophc_pkg::STATE_FRAC_BITS{1'b0}}};

	assign lp_ctrl = '{update: load_s2 && lp_en_q, clear: cfg_fire};
	assign hp_ctrl = '{update: load_s2 && hp_en_q, clear: cfg_fire};

	ophc_lowpass u_lowpass (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lp_ctrl),
		.coeff  (lp_coeff_q),
		.v_in   (v_in),
		.v_out  (lp_out)
	);

	// a disabled stage passes its input through
	assign v_lp = lp_en_q ? lp_out : v_in;

	ophc_highpass u_highpass (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hp_ctrl),
		.coeff  (hp_coeff_q),
		.v_in   (v_lp),
		.v_out  (hp_out)
	);

	assign v_hp = hp_en_q ? hp_out : v_lp;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			v_s2    <= v_hp;
			last_s2 <= last_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: divide by 2^16 toward zero
	// ---------------------------------------------------------------
	// floor of a 48-bit state over 2^16 is a 32-bit value; the round-up
	// only applies to negatives, so the sum never leaves the 32-bit range
	assign q_floor  = v_s2[ophc_pkg::STATE_W-1:ophc_pkg::STATE_FRAC_BITS];
	assign round_up = v_s2[ophc_pkg::STATE_W-1] && (|v_s2[ophc_pkg::STATE_FRAC_BITS-1:0]);
	assign q_out    = q_floor + ophc_pkg::SAMPLE_W'(round_up);

	always_ff @(posedge clk) begin
		if (load_s3) begin
			data_s3 <= q_out;
			last_s3 <= last_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = data_s3;
	assign m_axis_tlast  = last_s3;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`OPHC_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, valid_s1, "accepted word lost at input register")
	`OPHC_ASSERT_NEXT(a_bypass_exact, load_s2 && !lp_en_q && !hp_en_q, v_s2 == $past(v_in), "bypass path altered the sample")
	`OPHC_ASSERT_NEXT(a_drain_empties, m_axis_tvalid && m_axis_tready && !valid_s2, !m_axis_tvalid, "output word repeated after drain")
	`OPHC_ASSERT_SAME(a_no_overwrite, valid_s3 && !m_axis_tready, !load_s3, "stalled output register overwritten")

endmodule

FILE: sim/tb_one_pole_lowpass_highpass_cascade.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_one_pole_lowpass_highpass_cascade
// self-checking bench for the low-pass / dc blocker filter cascade
// ---------------------------------------------------------------------------
// Drives audio words into the input stream and predicts every output word
// with a bit-true fixed-point model of both filter stages kept in a
// scoreboard object. The run opens with a short directed set that hits the
// sample extremes, the reset value of the pole, every stage combination and
// the saturation paths. Random settings follow, each with its own burst of
// samples. Both stream sides idle at random, and once the output side holds
// off long enough to back the filter up. Filter settings are only changed
// once every predicted word has been seen.
// ---------------------------------------------------------------------------
module tb_one_pole_lowpass_highpass_cascade;

	localparam int RESET_CYCLES  = 7;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_WORDS  = 950;
	localparam int HOLD_CYCLES   = 64;      // long output stall for back-pressure
	localparam int TIMEOUT_NS    = 4000000;

	localparam logic [ophc_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
	localparam logic [ophc_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;
	localparam logic [ophc_pkg::SAMPLE_W-1:0] SAMPLE_NEG1 = 32'hFFFF_FFFF;

	// one output word as the filter should deliver it
	typedef struct packed {
		logic [ophc_pkg::SAMPLE_W-1:0] sample;
		logic                          last;
	} audio_word_t;

	// ----------------------------------------------------------------------
	// scoreboard: filter model plus queue of predicted words
	// ----------------------------------------------------------------------
	class filter_scoreboard;
		bit               smooth_on;
		bit               dc_block_on;
		ophc_pkg::coeff_t smooth_coeff;
		ophc_pkg::coeff_t pole_coeff;
		longint           smooth_acc;   // low-pass output, 16 fraction bits
		longint           dc_prev_in;   // previous dc blocker input
		longint           dc_acc;       // dc blocker output
		audio_word_t      predicted[$];
		int               mismatches;

		function new();
			smooth_on    = 1'b0;
			dc_block_on  = 1'b0;
			smooth_coeff = ophc_pkg::LP_COEFF_RESET;
			pole_coeff   = ophc_pkg::HP_COEFF_RESET;
			mismatches   = 0;
			clear_history();
		endfunction

		function void clear_history();
			smooth_acc = 0;
			dc_prev_in = 0;
			dc_acc     = 0;
		endfunction

		function longint clamp_state(longint v);
			longint hi;
			longint lo;
			hi = longint'(ophc_pkg::STATE_MAX);
			lo = longint'(ophc_pkg::STATE_MIN);
			if (v > hi) begin
				return hi;
			end else if (v < lo) begin
				return lo;
			end
			return v;
		endfunction

		// any accepted register write also wipes the filter history
		function void write_register(ophc_pkg::cfg_idx_t idx,
			logic [ophc_pkg::COEFF_W-1:0] data);
			case (idx)
				ophc_pkg::CFG_LP_ENABLE: smooth_on    = data[0];
				ophc_pkg::CFG_HP_ENABLE: dc_block_on  = data[0];
				ophc_pkg::CFG_LP_COEFF:  smooth_coeff = data;
				ophc_pkg::CFG_HP_COEFF:  pole_coeff   = data;
				default: return;
			endcase
			clear_history();
		endfunction

		// an accepted input word: run the model and queue the outcome
		function void note_sample(logic [ophc_pkg::SAMPLE_W-1:0] din, logic last);
			longint      v;
			longint      diff;
			longint      sum;
			longint      q;
			audio_word_t w;
			v = longint'($signed(din)) <<< ophc_pkg::STATE_FRAC_BITS;
			w.last = last;
			if (!smooth_on && !dc_block_on) begin
				w.sample = din;
			end else begin
				if (smooth_on) begin
					diff = clamp_state(v - smooth_acc);
					smooth_acc = clamp_state(smooth_acc +
						((diff * longint'(smooth_coeff)) >>> ophc_pkg::COEFF_FRAC_BITS));
					v = smooth_acc;
				end
				if (dc_block_on) begin
					sum = (v - dc_prev_in) +
						((dc_acc * longint'(pole_coeff)) >>> ophc_pkg::COEFF_FRAC_BITS);
					dc_acc = clamp_state(sum);
					dc_prev_in = v;
					v = dc_acc;
				end
				// divide truncates toward zero, then clamp to the sample range
				q = v / (longint'(1) <<< ophc_pkg::STATE_FRAC_BITS);
				if (q > longint'($signed(SAMPLE_MAX))) begin
					q = longint'($signed(SAMPLE_MAX));
				end else if (q < longint'($signed(SAMPLE_MIN))) begin
					q = longint'($signed(SAMPLE_MIN));
				end
				w.sample = q[ophc_pkg::SAMPLE_W-1:0];
			end
			predicted.push_back(w);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [ophc_pkg::SAMPLE_W-1:0] dout, logic last);
			audio_word_t w;
			if (predicted.size() == 0) begin
				report($sformatf("unexpected word sample=%h last=%b", dout, last));
				return;
			end
			w = predicted.pop_front();
			if (dout !== w.sample) begin
				report($sformatf("sample got %h want %h", dout, w.sample));
			end
			if (last !== w.last) begin
				report($sformatf("tlast got %b want %b", last, w.last));
			end
		endtask

		function int pending();
			return predicted.size();
		endfunction
	endclass

	// ----------------------------------------------------------------------
	// dut and its signals
	// ----------------------------------------------------------------------
	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [ophc_pkg::SAMPLE_W-1:0]  s_axis_tdata;   // [31:0] sample_in
	logic                           s_axis_tlast;   // block_end
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [ophc_pkg::SAMPLE_W-1:0]  m_axis_tdata;   // [31:0] sample_out
	logic                           m_axis_tlast;   // block_end_out
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ophc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ophc_pkg::COEFF_W-1:0]   cfg_data;

	one_pole_lowpass_highpass_cascade dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	filter_scoreboard sb = new();

	int send_idle_pct;   // chance in percent that the source skips a cycle
	int recv_idle_pct;   // chance in percent that the sink drops tready
	bit hold_off_req;    // asks the sink for one long stall

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#TIMEOUT_NS;
		$display("tb_one_pole_lowpass_highpass_cascade: FAIL");
		$finish;
	end

	// ----------------------------------------------------------------------
	// monitor: every handshake is seen at the rising edge, before the dut
	// flops move, so the values read here are the ones that were accepted
	// ----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_register(ophc_pkg::cfg_idx_t'(cfg_index), cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_sample(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tlast);
			end
		end
	end

	// ----------------------------------------------------------------------
	// sink: random tready, plus one counted stall on request
	// ----------------------------------------------------------------------
	initial begin : sink
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// ----------------------------------------------------------------------
	// driver tasks, all entered and left at a falling edge
	// ----------------------------------------------------------------------

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input ophc_pkg::cfg_idx_t idx,
		input logic [ophc_pkg::COEFF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// leaves tvalid high so back-to-back words need no second assignment
	task automatic send_sample(input logic [ophc_pkg::SAMPLE_W-1:0] d, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;   // junk while idle
			s_axis_tlast  <= 1'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// settings only move once every predicted word is out
	task automatic wait_idle();
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [ophc_pkg::COEFF_W-1:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return ophc_pkg::COEFF_W'($urandom_range(64000, 65535));   // pole near one
			3: return ophc_pkg::COEFF_W'($urandom_range(0, 2047));
			default: return ophc_pkg::COEFF_W'($urandom);
		endcase
	endfunction

	// enable words carry random upper bits, only bit 0 counts
	task automatic write_random_setting();
		write_reg(ophc_pkg::CFG_LP_ENABLE, {15'($urandom), 1'($urandom)});
		write_reg(ophc_pkg::CFG_HP_ENABLE, {15'($urandom), 1'($urandom)});
		write_reg(ophc_pkg::CFG_LP_COEFF, pick_coeff());
		write_reg(ophc_pkg::CFG_HP_COEFF, pick_coeff());
		if ($urandom_range(0, 3) == 0) begin
			write_reg(ophc_pkg::CFG_HP_ENABLE, 16'h0001);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ophc_pkg::SAMPLE_W-1:0] pick_sample(
		logic [ophc_pkg::SAMPLE_W-1:0] dc_level);
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return ophc_pkg::SAMPLE_W'($urandom_range(0, 8191)) - 32'd4096;
			4, 5, 6: return dc_level + ophc_pkg::SAMPLE_W'($urandom_range(0, 255)) - 32'd128;
			default: return $urandom;
		endcase
	endfunction

	// ----------------------------------------------------------------------
	// stimulus
	// ----------------------------------------------------------------------
	initial begin : stimulus
		int                            random_sent;
		int                            burst_len;
		bit                            pressure_done;
		logic [ophc_pkg::SAMPLE_W-1:0] dc_level;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= ophc_pkg::CFG_LP_ENABLE;
		cfg_data      <= '0;
		hold_off_req  = 1'b0;
		pressure_done = 1'b0;
		random_sent   = 0;
		send_idle_pct = 24;
		recv_idle_pct = 80;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: both stages off, samples pass straight through
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample('0, 1'b0);
		send_sample(SAMPLE_NEG1, 1'b0);
		send_sample(32'd1, 1'b1);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		// dc blocker alone on its reset pole: full-scale steps saturate
		write_reg(ophc_pkg::CFG_HP_ENABLE, 16'h0001);
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		// both on with the low-pass factor still at zero: output held at zero
		write_reg(ophc_pkg::CFG_LP_ENABLE, 16'h0001);
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		// low-pass alone at full factor, difference saturates on the swing
		write_reg(ophc_pkg::CFG_HP_ENABLE, 16'h0000);
		write_reg(ophc_pkg::CFG_LP_COEFF, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_NEG1, 1'b0);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		// cascade with a zero pole: plain first difference
		write_reg(ophc_pkg::CFG_HP_ENABLE, 16'h0001);
		write_reg(ophc_pkg::CFG_HP_COEFF, 16'h0000);
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample(32'd1, 1'b0);
		send_sample('0, 1'b0);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		// cascade with a half-scale smoother and the pole at its top
		write_reg(ophc_pkg::CFG_HP_COEFF, 16'hFFFF);
		write_reg(ophc_pkg::CFG_LP_COEFF, 16'h8000);
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('0, 1'b1);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		// random settings, each followed by a burst of samples
		while (random_sent < RANDOM_WORDS) begin
			// idle profile: slow sink, then slow source, then full rate
			if (random_sent < RANDOM_WORDS / 3) begin
				send_idle_pct = 24;
				recv_idle_pct = 80;
			end else if (random_sent < 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 80;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				if (!pressure_done) begin
					// sink stalls while the source keeps pushing
					hold_off_req  = 1'b1;
					pressure_done = 1'b1;
				end
			end
			write_random_setting();
			dc_level  = $urandom;
			burst_len = $urandom_range(10, 80);
			repeat (burst_len) begin
				send_sample(pick_sample(dc_level), ($urandom_range(0, 15) == 0));
				random_sent++;
			end
			s_axis_tvalid <= 1'b0;
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_one_pole_lowpass_highpass_cascade: PASS");
		end else begin
			$display("tb_one_pole_lowpass_highpass_cascade: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ophc_pkg.sv
rtl/core/ophc_lowpass.sv
rtl/core/ophc_highpass.sv
rtl/core/one_pole_lowpass_highpass_cascade.sv
sim/tb_one_pole_lowpass_highpass_cascade.sv
